// File: rtl/ckdk_pkg.sv
// ----------------------------------------------------------------------------
// ckdk_pkg
// Shared types, constants and helper functions for the canonical k-mer
// deletion key pipeline.
// ----------------------------------------------------------------------------
package ckdk_pkg;

  localparam int unsigned CodeW    = 62;
  localparam int unsigned KeyW     = 60;
  localparam int unsigned BaseW    = 2;
  localparam int unsigned LenW     = 5;
  localparam int unsigned AbundW   = 32;
  localparam int unsigned CfgIdxW  = 2;
  localparam int unsigned CfgDataW = 32;
  localparam int unsigned ShiftW   = 7;

  localparam logic [LenW-1:0] MaxBases = 5'd31;
  localparam logic [LenW-1:0] MinBases = 5'd3;

  localparam logic [LenW-1:0]   KmerLenReset = 5'd21;
  localparam logic [AbundW-1:0] LowCovReset  = 32'h0000_0000;
  localparam logic [AbundW-1:0] HighCovReset = 32'hFFFF_FFFF;

  localparam logic [BaseW-1:0] CompFlip = 2'b10;

  localparam logic [CfgIdxW-1:0] CfgKmerLength  = 2'd0;
  localparam logic [CfgIdxW-1:0] CfgLowCoverage = 2'd1;
  localparam logic [CfgIdxW-1:0] CfgHighCoverage = 2'd2;

  typedef struct packed {
    logic             kept;
    logic [CodeW-1:0] code;
    logic [LenW-1:0]  len;
  } front_t;

  typedef struct packed {
    logic             kept;
    logic [CodeW-1:0] code;
    logic [CodeW-1:0] rc;
    logic [LenW-1:0]  len;
  } rc_t;

  typedef struct packed {
    logic             kept;
    logic [CodeW-1:0] canon;
    logic [LenW-1:0]  len;
  } canon_t;

  typedef struct packed {
    logic             kept;
    logic [CodeW-1:0] canon;
    logic [KeyW-1:0]  key_mid;
    logic [BaseW-1:0] mid_base;
    logic [KeyW-1:0]  key_last;
    logic [BaseW-1:0] last_base;
    logic [KeyW-1:0]  key_first;
    logic [BaseW-1:0] first_base;
  } result_t;

  // Mask with the n lowest bits set.
  function automatic logic [CodeW-1:0] low_mask(input logic [ShiftW-1:0] n);
    logic [CodeW-1:0] m;
    m = '0;
    for (int b = 0; b < CodeW; b++) begin
      m[b] = (ShiftW'(b) < n);
    end
    return m;
  endfunction

endpackage

// File: rtl/canonical_kmer_deletion_keys.sv
// ----------------------------------------------------------------------------
// canonical_kmer_deletion_keys
// Canonical k-mer with middle, last and first base deletion keys, plus an
// abundance coverage check, in a four-stage pipeline.
// ----------------------------------------------------------------------------
//  Channel  | Handshake                  | Payload
//  ---------+----------------------------+------------------------------------
//  in       | in_valid_i / in_stall_o    | kmer_code_i, abundance_i
//  out      | out_valid_o / out_stall_i  | kept_o, canonical_kmer_o, keys, bases
//  cfg      | cfg_valid_i / cfg_ready_o  | cfg_index_i, cfg_data_i
//
// One item per cycle is accepted while in_stall_o is low; each result passes
// through the length/coverage, reverse complement, compare/select and key
// stages in turn. Each stage advances when it is empty or the next one moves,
// so bubbles are squeezed out and in_stall_o rises only when all four stages
// hold items. Reset clears the stage valid bits and loads the register defaults.
// ----------------------------------------------------------------------------
module canonical_kmer_deletion_keys (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  output logic                        in_stall_o,
  input  logic [ckdk_pkg::CodeW-1:0]    kmer_code_i,
  input  logic [ckdk_pkg::AbundW-1:0]   abundance_i,
  output logic                        out_valid_o,
  input  logic                        out_stall_i,
  output logic                        kept_o,
  output logic [ckdk_pkg::CodeW-1:0]    canonical_kmer_o,
  output logic [ckdk_pkg::KeyW-1:0]     key_without_middle_o,
  output logic [ckdk_pkg::BaseW-1:0]    middle_base_o,
  output logic [ckdk_pkg::KeyW-1:0]     key_without_last_o,
  output logic [ckdk_pkg::BaseW-1:0]    last_base_o,
  output logic [ckdk_pkg::KeyW-1:0]     key_without_first_o,
  output logic [ckdk_pkg::BaseW-1:0]    first_base_o,
  input  logic                        cfg_valid_i,
  output logic                        cfg_ready_o,
  input  logic [ckdk_pkg::CfgIdxW-1:0]  cfg_index_i,
  input  logic [ckdk_pkg::CfgDataW-1:0] cfg_data_i
);
  import ckdk_pkg::*;

  logic [LenW-1:0]   kmer_length_q;
  logic [AbundW-1:0] low_coverage_q;
  logic [AbundW-1:0] high_coverage_q;

  logic    en_front, en_rc, en_sel, en_keys;
  logic    front_valid, rc_valid, canon_valid, keys_valid;
  front_t  front_data;
  canon_t  canon_data;
  result_t result;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      kmer_length_q   <= KmerLenReset;
      low_coverage_q  <= LowCovReset;
      high_coverage_q <= HighCovReset;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        CfgKmerLength:   kmer_length_q   <= cfg_data_i[LenW-1:0];
        CfgLowCoverage:  low_coverage_q  <= cfg_data_i[AbundW-1:0];
        CfgHighCoverage: high_coverage_q <= cfg_data_i[AbundW-1:0];
        default: ;
      endcase
    end
  end

  assign cfg_ready_o = 1'b1;

  assign en_keys  = !keys_valid || !out_stall_i;
  assign en_sel   = !canon_valid || en_keys;
  assign en_rc    = !rc_valid || en_sel;
  assign en_front = !front_valid || en_rc;
  assign in_stall_o = !en_front;

  ckdk_front u_front (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .en_i            (en_front),
    .valid_i         (in_valid_i),
    .kmer_code_i     (kmer_code_i),
    .abundance_i     (abundance_i),
    .kmer_length_i   (kmer_length_q),
    .low_coverage_i  (low_coverage_q),
    .high_coverage_i (high_coverage_q),
    .valid_o         (front_valid),
    .data_o          (front_data)
  );

  ckdk_canon u_canon (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .en_rc_i    (en_rc),
    .en_sel_i   (en_sel),
    .valid_i    (front_valid),
    .data_i     (front_data),
    .rc_valid_o (rc_valid),
    .valid_o    (canon_valid),
    .data_o     (canon_data)
  );

  ckdk_keys u_keys (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en_keys),
    .valid_i (canon_valid),
    .data_i  (canon_data),
    .valid_o (keys_valid),
    .data_o  (result)
  );

  assign out_valid_o          = keys_valid;
  assign kept_o               = result.kept;
  assign canonical_kmer_o     = result.canon;
  assign key_without_middle_o = result.key_mid;
  assign middle_base_o        = result.mid_base;
  assign key_without_last_o   = result.key_last;
  assign last_base_o          = result.last_base;
  assign key_without_first_o  = result.key_first;
  assign first_base_o         = result.first_base;

endmodule

// File: rtl/ckdk_front.sv
// ----------------------------------------------------------------------------
// ckdk_front
// First stage: saturates the k-mer length, masks off bases above it and
// checks the abundance against the coverage range.
// ----------------------------------------------------------------------------
module ckdk_front (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      en_i,
  input  logic                      valid_i,
  input  logic [ckdk_pkg::CodeW-1:0]  kmer_code_i,
  input  logic [ckdk_pkg::AbundW-1:0] abundance_i,
  input  logic [ckdk_pkg::LenW-1:0]   kmer_length_i,
  input  logic [ckdk_pkg::AbundW-1:0] low_coverage_i,
  input  logic [ckdk_pkg::AbundW-1:0] high_coverage_i,
  output logic                      valid_o,
  output ckdk_pkg::front_t          data_o
);
  import ckdk_pkg::*;

  logic [LenW-1:0] len_sat;
  front_t          data_d, data_q;
  logic            valid_q;

  always_comb begin
    if (kmer_length_i < MinBases) begin
      len_sat = MinBases;
    end else if (kmer_length_i > MaxBases) begin
      len_sat = MaxBases;
    end else begin
      len_sat = kmer_length_i;
    end
    data_d.len  = len_sat;
    data_d.code = kmer_code_i & low_mask({1'b0, len_sat, 1'b0});
    data_d.kept = (abundance_i >= low_coverage_i) && (abundance_i <= high_coverage_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i && valid_i) begin
      data_q <= data_d;
    end
  end

  assign valid_o = valid_q;
  assign data_o  = data_q;

endmodule

// File: rtl/ckdk_canon.sv
// ----------------------------------------------------------------------------
// ckdk_canon
// Two stages: the reverse complement is formed and aligned to the k-mer
// length, then the lesser of the k-mer and its reverse complement is kept.
// ----------------------------------------------------------------------------
module ckdk_canon (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             en_rc_i,
  input  logic             en_sel_i,
  input  logic             valid_i,
  input  ckdk_pkg::front_t data_i,
  output logic             rc_valid_o,
  output logic             valid_o,
  output ckdk_pkg::canon_t data_o
);
  import ckdk_pkg::*;

  logic [CodeW-1:0]  rev_full;
  logic [ShiftW-1:0] shamt;
  rc_t               rc_d, rc_q;
  logic              rc_valid_q;
  canon_t            canon_d, canon_q;
  logic              canon_valid_q;

  always_comb begin
    for (int i = 0; i < int'(MaxBases); i++) begin
      rev_full[BaseW*(int'(MaxBases)-1-i) +: BaseW] = data_i.code[BaseW*i +: BaseW] ^ CompFlip;
    end
    shamt      = {1'b0, MaxBases - data_i.len, 1'b0};
    rc_d.kept  = data_i.kept;
    rc_d.code  = data_i.code;
    rc_d.len   = data_i.len;
    rc_d.rc    = rev_full >> shamt;
  end

  always_comb begin
    canon_d.kept  = rc_q.kept;
    canon_d.len   = rc_q.len;
    canon_d.canon = (rc_q.code < rc_q.rc) ? rc_q.code : rc_q.rc;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rc_valid_q    <= 1'b0;
      canon_valid_q <= 1'b0;
    end else begin
      if (en_rc_i) begin
        rc_valid_q <= valid_i;
      end
      if (en_sel_i) begin
        canon_valid_q <= rc_valid_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_rc_i && valid_i) begin
      rc_q <= rc_d;
    end
    if (en_sel_i && rc_valid_q) begin
      canon_q <= canon_d;
    end
  end

  assign rc_valid_o = rc_valid_q;
  assign valid_o    = canon_valid_q;
  assign data_o     = canon_q;

endmodule

// File: rtl/ckdk_keys.sv
// ----------------------------------------------------------------------------
// ckdk_keys
// Last stage: derives the three deletion keys and the deleted bases from the
// canonical k-mer and holds the finished item in the output register.
// ----------------------------------------------------------------------------
module ckdk_keys (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              en_i,
  input  logic              valid_i,
  input  ckdk_pkg::canon_t  data_i,
  output logic              valid_o,
  output ckdk_pkg::result_t data_o
);
  import ckdk_pkg::*;

  logic [LenW-2:0]   mid;
  logic [ShiftW-1:0] mid_idx;
  logic [ShiftW-1:0] first_idx;
  logic [CodeW-1:0]  mid_mask;
  logic [CodeW-1:0]  first_mask;
  logic [CodeW-1:0]  key_mid_full;
  logic [CodeW-1:0]  key_first_full;
  result_t           res_d, res_q;
  logic              valid_q;

  always_comb begin
    mid            = data_i.len[LenW-1:1];
    mid_idx        = {1'b0, 1'b0, mid, 1'b0};
    first_idx      = {1'b0, data_i.len - 5'd1, 1'b0};
    mid_mask       = low_mask(mid_idx);
    first_mask     = low_mask(first_idx);
    key_mid_full   = ((data_i.canon >> 2) & ~mid_mask) | (data_i.canon & mid_mask);
    key_first_full = data_i.canon & first_mask;

    res_d.kept       = data_i.kept;
    res_d.canon      = data_i.canon;
    res_d.key_mid    = key_mid_full[KeyW-1:0];
    res_d.mid_base   = data_i.canon[mid_idx[ShiftW-2:0] +: BaseW];
    res_d.key_last   = data_i.canon[CodeW-1:BaseW];
    res_d.last_base  = data_i.canon[BaseW-1:0];
    res_d.key_first  = key_first_full[KeyW-1:0];
    res_d.first_base = data_i.canon[first_idx[ShiftW-2:0] +: BaseW];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i && valid_i) begin
      res_q <= res_d;
    end
  end

  assign valid_o = valid_q;
  assign data_o  = res_q;

endmodule

// File: rtl/ckdk_checker.sv
// ----------------------------------------------------------------------------
// ckdk_checker
// Port-level checks for canonical_kmer_deletion_keys, bound to the top level.
// ----------------------------------------------------------------------------
module ckdk_checker (
  input logic                        clk_i,
  input logic                        rst_ni,
  input logic                        in_stall_o,
  input logic                        out_valid_o,
  input logic                        out_stall_i,
  input logic [ckdk_pkg::CodeW-1:0]    canonical_kmer_o,
  input logic [ckdk_pkg::KeyW-1:0]     key_without_last_o,
  input logic [ckdk_pkg::BaseW-1:0]    last_base_o,
  input logic                        cfg_ready_o
);
  import ckdk_pkg::*;

  // A result that is held back stays offered.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o)
    else $error("result withdrawn while stalled");

  // With the output side free, the pipeline never pushes back on its input.
  a_no_false_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_stall_i |-> !in_stall_o)
    else $error("input stalled while output is free");

  a_cfg_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cfg_ready_o)
    else $error("configuration port not ready");

  // The key without the last base is the canonical k-mer shifted down one base, and the last base is its lowest base.
  a_last_key: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (key_without_last_o == canonical_kmer_o[CodeW-1:BaseW]) &&
                    (last_base_o == canonical_kmer_o[BaseW-1:0]))
    else $error("last-base key does not match canonical k-mer");

endmodule

bind canonical_kmer_deletion_keys ckdk_checker u_ckdk_checker (
  .clk_i              (clk_i),
  .rst_ni             (rst_ni),
  .in_stall_o         (in_stall_o),
  .out_valid_o        (out_valid_o),
  .out_stall_i        (out_stall_i),
  .canonical_kmer_o   (canonical_kmer_o),
  .key_without_last_o (key_without_last_o),
  .last_base_o        (last_base_o),
  .cfg_ready_o        (cfg_ready_o)
);
